// ----- hw/rtl/c3s_pkg.sv -----
// Shared types and constants of the 3x3 stencil core.
package c3s_pkg;

	localparam int PIX_W    = 16;
	localparam int WGT_W    = 16;
	localparam int PROD_W   = PIX_W + 1 + WGT_W;
	localparam int ROWSUM_W = PROD_W + 2;
	localparam int SUM_W    = 36;
	localparam int POS_W    = 10;
	localparam int DIM_W    = 11;
	localparam int COEF_W   = 3 * WGT_W;
	localparam int CFG_W    = COEF_W;
	localparam int CFG_IDX_W = 3;
	localparam int DIM_MIN  = 3;
	localparam int WIN_EDGE = 2;
	localparam int TAPS     = 3;

	localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_COLS = 3'd0,
		CFG_FRAME_ROWS = 3'd1,
		CFG_COEF_TOP   = 3'd2,
		CFG_COEF_MID   = 3'd3,
		CFG_COEF_BOT   = 3'd4
	} cfg_idx_t;

	typedef logic        [PIX_W-1:0]  pix_t;
	typedef logic signed [WGT_W-1:0]  wgt_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic shift;
		logic mul;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/c3s_line_store.sv -----
// One line store: single write port, registered read port.
module c3s_line_store
	import c3s_pkg::*;
#(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  pix_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output pix_t          rdata
);

	pix_t mem [DEPTH];
	pix_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/c3s_tap_cell.sv -----
// Window tap cell: holds one pixel, passes it left, registers its weighted product.
module c3s_tap_cell
	import c3s_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  pix_t      pix_in,
	input  wgt_t      weight,
	output pix_t      pix,
	output prod_t     prod
);

	pix_t  pix_q;
	prod_t prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (ctl.shift) begin
			pix_q <= pix_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s3 <= $signed({1'b0, pix_q}) * weight;
		end
	end

	assign pix  = pix_q;
	assign prod = prod_s3;

endmodule

// ----- hw/rtl/conv3x3_stencil_core.sv -----
// Top level of the 3x3 stencil core: counters, line stores, tap cells and adder pipeline.
// A pixel goes through read, shift, multiply and row-sum stages into the output register.
// Throughput: one pixel per cycle unless out_ready stalls it, set by the line store read
// register feeding the tap cell chain and the multiply, row-sum and total-sum stages.
// Reset clears the counters, configuration registers, window and stage valids; the line
// stores are not cleared; a result uses only line store data that the current frame wrote.
module conv3x3_stencil_core
	import c3s_pkg::*;
#(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PIX_W-1:0]        pixel,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SUM_W-1:0] weighted_sum,
	output logic [POS_W-1:0]        out_row,
	output logic [POS_W-1:0]        out_col,
	output logic                    frame_end
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CDW = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
	localparam int RDW = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;
	localparam int PCW = (CW > POS_W) ? CW : POS_W;
	localparam int PRW = (RW > POS_W) ? RW : POS_W;

	// configuration
	logic [DIM_W-1:0]  frame_cols_q, frame_rows_q;
	logic [COEF_W-1:0] coef_q [TAPS];
	logic [CDW-1:0]    cols_use, fc_ext;
	logic [RDW-1:0]    rows_use, fr_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cols_q <= DIM_RST;
			frame_rows_q <= DIM_RST;
			coef_q[0]    <= '0;
			coef_q[1]    <= '0;
			coef_q[2]    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FRAME_COLS: frame_cols_q <= cfg_wdata[DIM_W-1:0];
				CFG_FRAME_ROWS: frame_rows_q <= cfg_wdata[DIM_W-1:0];
				CFG_COEF_TOP:   coef_q[0]    <= cfg_wdata[COEF_W-1:0];
				CFG_COEF_MID:   coef_q[1]    <= cfg_wdata[COEF_W-1:0];
				CFG_COEF_BOT:   coef_q[2]    <= cfg_wdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		fc_ext = CDW'(frame_cols_q);
		fr_ext = RDW'(frame_rows_q);
		if (fc_ext < CDW'(DIM_MIN)) begin
			cols_use = CDW'(DIM_MIN);
		end else if (fc_ext > CDW'(MAX_COLS)) begin
			cols_use = CDW'(MAX_COLS);
		end else begin
			cols_use = fc_ext;
		end
		if (fr_ext < RDW'(DIM_MIN)) begin
			rows_use = RDW'(DIM_MIN);
		end else if (fr_ext > RDW'(MAX_ROWS)) begin
			rows_use = RDW'(MAX_ROWS);
		end else begin
			rows_use = fr_ext;
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;
	logic in_fire, adv1, adv2;

	assign rdy_out = !out_valid_q || out_ready;
	assign rdy4    = !v_s4 || rdy_out;
	assign rdy3    = !v_s3 || rdy4;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign in_fire  = in_valid && rdy1;
	assign adv1     = v_s1 && rdy2;
	assign adv2     = v_s2 && rdy3;

	// position counters
	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [CDW-1:0] c_inc;
	logic [RDW-1:0] r_inc;

	assign c_inc = CDW'(c_q) + CDW'(1);
	assign r_inc = RDW'(r_q) + RDW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (in_fire) begin
			if (c_inc >= cols_use) begin
				c_q <= '0;
				if (r_inc >= rows_use) begin
					r_q <= '0;
				end else begin
					r_q <= r_inc[RW-1:0];
				end
			end else begin
				c_q <= c_inc[CW-1:0];
			end
		end
	end

	// stage 1: line store read
	pix_t          px_s1, rd_a, rd_b;
	logic [CW-1:0] c_s1;
	logic [RW-1:0] r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1 <= pixel;
			c_s1  <= c_q;
			r_s1  <= r_q;
		end
	end

	c3s_line_store #(.DEPTH(MAX_COLS)) u_store_a (
		.clk   (clk),
		.we    (in_fire),
		.waddr (c_q),
		.wdata (pixel),
		.re    (in_fire),
		.raddr (c_q),
		.rdata (rd_a)
	);

	c3s_line_store #(.DEPTH(MAX_COLS)) u_store_b (
		.clk   (clk),
		.we    (adv1),
		.waddr (c_s1),
		.wdata (rd_a),
		.re    (in_fire),
		.raddr (c_q),
		.rdata (rd_b)
	);

	// stage 2: window shift, position and emit decision
	logic             emit_s2, end_s2, end_s3, end_s4;
	logic [POS_W-1:0] row_s2, col_s2, row_s3, col_s3, row_s4, col_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			emit_s2 <= (c_s1 >= CW'(WIN_EDGE)) && (r_s1 >= RW'(WIN_EDGE));
			row_s2  <= POS_W'(PRW'(r_s1) - PRW'(1));
			col_s2  <= POS_W'(PCW'(c_s1) - PCW'(1));
			end_s2  <= (RDW'(r_s1) == rows_use - RDW'(1)) &&
				(CDW'(c_s1) == cols_use - CDW'(1));
		end
	end

	// tap cell chains, one per window row
	cell_ctl_t ctl;
	pix_t      col_in [TAPS];
	pix_t      win    [TAPS][TAPS];
	prod_t     prod   [TAPS][TAPS];

	assign ctl.shift = adv1;
	assign ctl.mul   = adv2 && emit_s2;
	assign col_in[0] = rd_b;
	assign col_in[1] = rd_a;
	assign col_in[2] = px_s1;

	for (genvar gr = 0; gr < TAPS; gr++) begin : g_row
		for (genvar gk = 0; gk < TAPS; gk++) begin : g_tap
			pix_t tap_in;
			if (gk == TAPS - 1) begin : g_entry
				assign tap_in = col_in[gr];
			end else begin : g_link
				assign tap_in = win[gr][gk+1];
			end
			c3s_tap_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.pix_in (tap_in),
				.weight (wgt_t'(coef_q[gr][gk*WGT_W +: WGT_W])),
				.pix    (win[gr][gk]),
				.prod   (prod[gr][gk])
			);
		end
	end

	// stage 3: products held in cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			row_s3 <= row_s2;
			col_s3 <= col_s2;
			end_s3 <= end_s2;
		end
	end

	// stage 4: row sums
	logic signed [ROWSUM_W-1:0] rsum_s4 [TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy4) begin
			for (int i = 0; i < TAPS; i++) begin
				rsum_s4[i] <= ROWSUM_W'(prod[i][0]) + ROWSUM_W'(prod[i][1]) +
					ROWSUM_W'(prod[i][2]);
			end
			row_s4 <= row_s3;
			col_s4 <= col_s3;
			end_s4 <= end_s3;
		end
	end

	// output register: total
	logic signed [SUM_W-1:0] sum_q;
	logic [POS_W-1:0]        row_q, col_q;
	logic                    end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && rdy_out) begin
			sum_q <= SUM_W'(rsum_s4[0]) + SUM_W'(rsum_s4[1]) + SUM_W'(rsum_s4[2]);
			row_q <= row_s4;
			col_q <= col_s4;
			end_q <= end_s4;
		end
	end

	assign out_valid    = out_valid_q;
	assign weighted_sum = sum_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign frame_end    = end_q;

	// checks
	a_store_b_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && in_fire) |-> (c_q != c_s1))
		else $error("line store b written at the column being read");

	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s4))
		else $error("result appeared without an item in the row-sum stage");

	a_border_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !emit_s2 && rdy3) |=> !v_s3)
		else $error("border item entered the multiply stage");

endmodule
